[hw/rtl/rsnh_pkg.sv]
// ----------------------------------------------------------------------------
// rsnh_pkg
// Shared types, register indexes, sequencer states and default parameter
// values for the ray/segment nearest-hit block.
// ----------------------------------------------------------------------------
package rsnh_pkg;

  localparam int NUM_RAY_COUNT_DEF    = 64;
  localparam int MAX_SEGMENTS_DEF     = 256;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int COORD_FRAC_BITS_DEF  = 8;

  // quotient bits kept by the divider; anything at 2^24 or above saturates
  localparam int QUO_W = 25;
  // magnitude of the cross-product denominator
  localparam int DEN_W = 34;

  localparam logic [15:0] FOV_RESET  = 16'd10923;
  localparam logic [23:0] DIST_RESET = 24'd256000;

  typedef enum logic [2:0] {
    REG_PLAYER_X  = 3'd0,
    REG_PLAYER_Y  = 3'd1,
    REG_VIEW      = 3'd2,
    REG_FOV       = 3'd3,
    REG_MAX_DIST  = 3'd4,
    REG_SEG_COUNT = 3'd5
  } reg_index_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [7:0]         seg_index;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by_coord;
    logic [5:0]         ray_number;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  ray_out;
    logic [23:0] distance;
    logic        hit;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_INDEX,
    ST_ROM,
    ST_READ,
    ST_MUL,
    ST_TEST,
    ST_DIV,
    ST_DONE
  } seq_state_t;

endpackage

[hw/rtl/rsnh_ram.sv]
// ----------------------------------------------------------------------------
// rsnh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsnh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/rsnh_sine_rom.sv]
// ----------------------------------------------------------------------------
// rsnh_sine_rom
// Sine table in signed Q1.14 with two registered read ports (sin and cos).
// Contents are computed at elaboration.
// ----------------------------------------------------------------------------
module rsnh_sine_rom #(
  parameter int DEPTH = 1024,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic [IW-1:0]      sin_addr,
  input  logic [IW-1:0]      cos_addr,
  output logic signed [15:0] sin_val,
  output logic signed [15:0] cos_val
);

  typedef logic signed [15:0] sine_tab_t [DEPTH];

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

  // round(16384 * sin(num/DEPTH * pi/2)) by a Taylor series in Q30
  function automatic longint quarter_sine(longint unsigned num);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          r;
    x    = num * PI_HALF_Q30 / DEPTH;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum * 16384 + (64'sd1 <<< 29)) >>> 30;
    if (r > 16384) r = 16384;
    return r;
  endfunction

  function automatic sine_tab_t build_table();
    sine_tab_t       tab;
    longint unsigned p;
    longint unsigned q;
    longint unsigned rr;
    longint          v;
    for (int i = 0; i < DEPTH; i++) begin
      p  = longint'(i) * 4;
      q  = p / DEPTH;
      rr = p % DEPTH;
      v  = q[0] ? quarter_sine(DEPTH - rr) : quarter_sine(rr);
      tab[i] = 16'((q >= 2) ? -v : v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_table();

  always_ff @(posedge clk) begin
    sin_val <= SINE_TAB[sin_addr];
    cos_val <= SINE_TAB[cos_addr];
  end

endmodule

[hw/rtl/rsnh_div.sv]
// ----------------------------------------------------------------------------
// rsnh_div
// Restoring unsigned divider, one quotient bit per cycle. Flags quotients
// that do not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module rsnh_div
  import rsnh_pkg::*;
#(
  parameter int NUM_W = 56
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic             over,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] low_bits;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] head;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign head   = num >> QUO_W;
  assign rem_sh = {rem, low_bits[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt      <= CNT_W'(QUO_W);
      done     <= 1'b0;
      den_q    <= den;
      over     <= head >= NUM_W'(den);
      rem      <= DEN_W'(head);
      low_bits <= num[QUO_W-1:0];
    end else if (cnt != '0) begin
      rem      <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      low_bits <= low_bits << 1;
      quo      <= {quo[QUO_W-2:0], ge};
      cnt      <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

endmodule

[hw/rtl/ray_segment_nearest_hit.sv]
// ----------------------------------------------------------------------------
// ray_segment_nearest_hit
// Nearest wall hit along one ray of a viewing fan, scanning a segment RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries two kinds of item.
//   A write (op 0) stores segment ax,ay,bx,by_coord at seg_index in the
//   segment RAM in the cycle it is accepted and yields no result. Writes
//   can be accepted one per cycle while no cast is in progress.
//   A cast (op 1) produces one result item on the output channel
//   (out_valid / out_stall / out_item): the ray number, the nearest hit
//   distance in Q16.8 (miss_dist when nothing is hit) and a hit flag.
//   A cast scans segment_count entries, clamped to the table size: the fan
//   offset ray*fov/NUM_RAY_COUNT comes from a reciprocal multiply, the
//   segment RAM is walked one entry at a time (read, multiply, test), and
//   every segment that passes the crossing test has its hit distance
//   computed in a restoring divider (25 quotient bits, one per cycle).
//   One item is worked on at a time; in_stall stays high until the current
//   cast has handed its result to the output register.
//   The output register holds a finished result while out_stall is high; the
//   block meanwhile accepts writes, and a new cast runs up to its final
//   hand-off step.
//   Reset clears control state and reloads the configuration defaults;
//   the segment RAM is not cleared, so only written entries may be scanned.
//   Configuration is an APB-style port, register i at byte address 4*i.
// ----------------------------------------------------------------------------
module ray_segment_nearest_hit
  import rsnh_pkg::*;
#(
  parameter int NUM_RAY_COUNT    = NUM_RAY_COUNT_DEF,
  parameter int MAX_SEGMENTS     = MAX_SEGMENTS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  localparam int F     = COORD_FRAC_BITS;
  localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int IW    = $clog2(SINE_TABLE_DEPTH);
  // player offset from segment start, QF
  localparam int PX_W  = ((24 > 16 + F) ? 24 : 16 + F) + 1;
  // signed width of the cross-product sums
  localparam int TW    = PX_W + 18;
  localparam int NUM_W = TW - 1 + 14;
  // reciprocal of the ray count, exact for products below 2^22
  localparam int          RCP_SH = 22 + $clog2(NUM_RAY_COUNT);
  localparam logic [23:0] RCP_M  =
    24'(((64'd1 << RCP_SH) + 64'(NUM_RAY_COUNT) - 64'd1) / 64'(NUM_RAY_COUNT));

  // ---------------- configuration registers ----------------
  logic [23:0] player_x;
  logic [23:0] player_y;
  logic [15:0] view_angle;
  logic [15:0] field_of_view;
  logic [23:0] miss_dist;
  logic [8:0]  segment_count;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= '0;
      player_y      <= '0;
      view_angle    <= '0;
      field_of_view <= FOV_RESET;
      miss_dist     <= DIST_RESET;
      segment_count <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_PLAYER_X:  player_x      <= pwdata[23:0];
        REG_PLAYER_Y:  player_y      <= pwdata[23:0];
        REG_VIEW:      view_angle    <= pwdata[15:0];
        REG_FOV:       field_of_view <= pwdata[15:0];
        REG_MAX_DIST:  miss_dist     <= pwdata[23:0];
        REG_SEG_COUNT: segment_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PLAYER_X:  prdata = {8'd0, player_x};
      REG_PLAYER_Y:  prdata = {8'd0, player_y};
      REG_VIEW:      prdata = {16'd0, view_angle};
      REG_FOV:       prdata = {16'd0, field_of_view};
      REG_MAX_DIST:  prdata = {8'd0, miss_dist};
      REG_SEG_COUNT: prdata = {23'd0, segment_count};
      default:       prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  seq_state_t       state, state_next;
  logic [CW-1:0]    cursor;
  logic [23:0]      best;
  logic [5:0]       ray_q;
  logic [21:0]      fan_q;
  logic [15:0]      angle;
  logic [IW-1:0]    sin_idx;
  logic [IW-1:0]    cos_idx;

  logic             accept;
  logic             wr_en;
  logic [CW-1:0]    n_eff;
  logic             out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // clamp the scan length to the table size
  assign n_eff = (13'(segment_count) > 13'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                          : CW'(segment_count);

  // drop writes beyond the table
  assign wr_en = accept && (in_item.op == OP_WRITE) &&
                 (13'(in_item.seg_index) < 13'(MAX_SEGMENTS));

  // ---------------- segment RAM ----------------
  logic [63:0] seg_rdata;

  rsnh_ram #(
    .WIDTH (64),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_item.seg_index)),
    .wr_data ({in_item.by_coord, in_item.bx, in_item.ay, in_item.ax}),
    .rd_addr (cursor[AW-1:0]),
    .rd_data (seg_rdata)
  );

  // ---------------- sine ROM ----------------
  logic signed [15:0] ry;
  logic signed [15:0] rx;

  rsnh_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk      (clk),
    .sin_addr (sin_idx),
    .cos_addr (cos_idx),
    .sin_val  (ry),
    .cos_val  (rx)
  );

  // ---------------- angle and ROM index ----------------
  logic [45:0] fan_scaled;
  logic [31:0] idx_prod;
  logic [IW:0] cos_sum;
  logic [IW:0] cos_wrap;

  // ray * fov / NUM_RAY_COUNT by reciprocal multiplication
  assign fan_scaled = 46'(fan_q) * 46'(RCP_M);

  assign idx_prod = 32'(angle) * 32'(SINE_TABLE_DEPTH);
  assign cos_sum  = {1'b0, idx_prod[16 +: IW]} + (IW+1)'(SINE_TABLE_DEPTH / 4);
  assign cos_wrap = (cos_sum >= (IW+1)'(SINE_TABLE_DEPTH))
                  ? cos_sum - (IW+1)'(SINE_TABLE_DEPTH) : cos_sum;

  // ---------------- multiply stage ----------------
  logic signed [15:0]      s_ax, s_ay, s_bx, s_by;
  logic signed [16:0]      dx, dy;
  logic signed [PX_W-1:0]  px, py;
  logic signed [32:0]      m_dx_ry, m_dy_rx;
  logic signed [PX_W+15:0] m_px_ry, m_py_rx;
  logic signed [PX_W+16:0] m_px_dy, m_py_dx;

  assign s_ax = seg_rdata[15:0];
  assign s_ay = seg_rdata[31:16];
  assign s_bx = seg_rdata[47:32];
  assign s_by = seg_rdata[63:48];
  assign dx   = 17'(s_bx) - 17'(s_ax);
  assign dy   = 17'(s_by) - 17'(s_ay);
  assign px   = PX_W'($signed(player_x)) - (PX_W'(s_ax) <<< F);
  assign py   = PX_W'($signed(player_y)) - (PX_W'(s_ay) <<< F);

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      m_dx_ry <= dx * ry;
      m_dy_rx <= dy * rx;
      m_px_ry <= px * ry;
      m_py_rx <= py * rx;
      m_px_dy <= px * dy;
      m_py_dx <= py * dx;
    end
  end

  // ---------------- crossing test ----------------
  logic signed [TW-1:0] den_s, tn_s, un_s;
  logic signed [TW-1:0] den_a, tn_a, un_a;
  logic                 seg_pass;

  assign den_s = TW'(m_dx_ry) - TW'(m_dy_rx);
  assign tn_s  = TW'(m_px_ry) - TW'(m_py_rx);
  assign un_s  = TW'(m_px_dy) - TW'(m_py_dx);
  // flip all three so the denominator is positive
  assign den_a = den_s[TW-1] ? -den_s : den_s;
  assign tn_a  = den_s[TW-1] ? -tn_s  : tn_s;
  assign un_a  = den_s[TW-1] ? -un_s  : un_s;

  assign seg_pass = (den_s != '0) && !tn_a[TW-1] && !un_a[TW-1] &&
                    (tn_a <= (den_a <<< F));

  // ---------------- hit distance divider ----------------
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic             div_over;
  logic [QUO_W-1:0] div_quo;
  logic [QUO_W-1:0] dist_new;

  assign div_num   = {un_a[TW-2:0], 14'd0};
  assign div_den   = den_a[DEN_W-1:0];
  assign div_start = (state == ST_TEST) && seg_pass;

  rsnh_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .over  (div_over),
    .quo   (div_quo)
  );

  // saturate at 2^24, which never beats miss_dist
  assign dist_new = (div_over || div_quo[QUO_W-1]) ? {1'b1, {(QUO_W-1){1'b0}}}
                                                   : div_quo;

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && (in_item.op == OP_CAST)) state_next = ST_ANGLE;
      ST_ANGLE: state_next = ST_INDEX;
      ST_INDEX: state_next = ST_ROM;
      ST_ROM:   state_next = ST_READ;
      ST_READ:  state_next = (cursor == n_eff) ? ST_DONE : ST_MUL;
      ST_MUL:   state_next = ST_TEST;
      ST_TEST:  state_next = seg_pass ? ST_DIV : ST_READ;
      ST_DIV:   if (div_done) state_next = ST_READ;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      best   <= '0;
    end else begin
      case (state)
        ST_ROM: begin
          cursor <= '0;
          best   <= miss_dist;
        end
        ST_TEST: if (!seg_pass) cursor <= cursor + CW'(1);
        ST_DIV: begin
          if (div_done) begin
            cursor <= cursor + CW'(1);
            if (dist_new < {1'b0, best}) best <= dist_new[23:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ray_q <= in_item.ray_number;
      fan_q <= 22'(in_item.ray_number) * 22'(field_of_view);
    end
    if (state == ST_ANGLE) begin
      angle <= view_angle - (field_of_view >> 1) + fan_scaled[RCP_SH +: 16];
    end
    if (state == ST_INDEX) begin
      sin_idx <= idx_prod[16 +: IW];
      cos_idx <= cos_wrap[IW-1:0];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_item.ray_out  <= ray_q;
      out_item.distance <= best;
      out_item.hit      <= best < miss_dist;
    end
  end

endmodule
